### sv/rrlp_pkg.sv
// Shared types and constants of the reader response line parser.
`default_nettype none

package rrlp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_TAG   = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;

    // Reader models.
    localparam logic [1:0] MODEL_NONE = 2'd0;
    localparam logic [1:0] MODEL_LF   = 2'd1;
    localparam logic [1:0] MODEL_HF   = 2'd2;

    // Special characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [6:0] CH_DASH  = 7'h2D;

    localparam int IDENT_LF_LEN = 15;
    localparam int IDENT_HF_LEN = 16;

    // Identity string of the 125 kHz reader; the final entry is padding.
    localparam logic [6:0] IDENT_LF [16] = '{
        7'h4D, 7'h4F, 7'h44, 7'h2D, 7'h52, 7'h46, 7'h49, 7'h44,
        7'h31, 7'h32, 7'h35, 7'h2D, 7'h42, 7'h4F, 7'h58, 7'h00
    };

    // Identity string of the 13.56 MHz reader.
    localparam logic [6:0] IDENT_HF [16] = '{
        7'h4D, 7'h4F, 7'h44, 7'h2D, 7'h52, 7'h46, 7'h49, 7'h44,
        7'h31, 7'h33, 7'h35, 7'h36, 7'h2D, 7'h42, 7'h4F, 7'h58
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // input beat accepted
        logic rd;        // read the line store at the tag index
        logic load_tag;  // load the read character into the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic single;    // the offered beat ends a line with one result
        logic tags;      // the offered beat ends a tag line with characters
        logic out_last;  // the result register holds the final result
    } status_t;

endpackage

`default_nettype wire

### sv/rrlp_ctrl.sv
// Controller state machine of the reader response line parser.
`default_nettype none

module rrlp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire rrlp_pkg::status_t status,
    output rrlp_pkg::cmd_t         cmd
);

    rrlp_pkg::state_t state_reg;
    rrlp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrlp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrlp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (status.tags) begin
                        state_next = rrlp_pkg::ST_READ;
                    end else if (status.single) begin
                        state_next = rrlp_pkg::ST_SEND;
                    end
                end
            end
            rrlp_pkg::ST_READ: begin
                state_next = rrlp_pkg::ST_LOAD;
            end
            rrlp_pkg::ST_LOAD: begin
                state_next = rrlp_pkg::ST_SEND;
            end
            rrlp_pkg::ST_SEND: begin
                if (m_ready) begin
                    state_next = status.out_last ? rrlp_pkg::ST_IDLE : rrlp_pkg::ST_READ;
                end
            end
            default: begin
                state_next = rrlp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.take     = 1'b0;
        cmd.rd       = 1'b0;
        cmd.load_tag = 1'b0;
        case (state_reg)
            rrlp_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            rrlp_pkg::ST_READ: begin
                cmd.rd = 1'b1;
            end
            rrlp_pkg::ST_LOAD: begin
                cmd.load_tag = 1'b1;
            end
            rrlp_pkg::ST_SEND: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/rrlp_datapath.sv
// Datapath of the reader response line parser: line store, matching and result register.
`default_nettype none

module rrlp_datapath #(
    parameter int LINE_LEN = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rrlp_pkg::cmd_t  cmd,
    output rrlp_pkg::status_t    status,
    input  wire logic            s_action,
    input  wire logic [7:0]      s_rx_byte,
    output logic [1:0]           m_kind,
    output logic [6:0]           m_tag_char,
    output logic                 m_last,
    output logic [1:0]           m_reader_model
);

    localparam int PW = $clog2(LINE_LEN);
    localparam logic [PW-1:0] FULL_LEN = PW'(LINE_LEN - 1);
    localparam logic [PW-1:0] LF_LEN   = PW'(rrlp_pkg::IDENT_LF_LEN);
    localparam logic [PW-1:0] HF_LEN   = PW'(rrlp_pkg::IDENT_HF_LEN);

    logic [6:0]    line_mem [LINE_LEN];
    logic [6:0]    rd_data_reg;
    logic [PW-1:0] pos_reg;
    logic [1:0]    model_reg;
    logic [6:0]    first_reg;
    logic          match_lf_reg;
    logic          match_hf_reg;
    logic [PW-1:0] idx_reg;
    logic [PW-1:0] tag_last_reg;

    logic          byte_ok;
    logic          is_term;
    logic          is_store;
    logic [PW-1:0] pos_inc;
    logic          full;
    logic          line_end;
    logic [PW-1:0] len;
    logic          match_lf_next;
    logic          match_hf_next;
    logic          match_lf_cur;
    logic          match_hf_cur;
    logic          is_dash;
    logic          hit_lf;
    logic          hit_hf;
    logic          empty_tag;
    logic [1:0]    model_next;

    assign byte_ok  = !s_action && !s_rx_byte[7] && (s_rx_byte != rrlp_pkg::CH_DEL);
    assign is_term  = (s_rx_byte == rrlp_pkg::CH_CR) || (s_rx_byte == rrlp_pkg::CH_LF)
                   || (s_rx_byte == rrlp_pkg::CH_NUL);
    assign is_store = byte_ok && !is_term;
    assign pos_inc  = pos_reg + PW'(1);
    assign full     = is_store && (pos_inc == FULL_LEN);
    assign line_end = byte_ok && (is_term || full);
    assign len      = is_term ? pos_reg : pos_inc;

    // The identity strings are matched one character at a time as the line is stored.
    assign match_lf_next = ((pos_reg == '0) || match_lf_reg) && (pos_reg < LF_LEN)
                        && (s_rx_byte[6:0] == rrlp_pkg::IDENT_LF[pos_reg[3:0]]);
    assign match_hf_next = ((pos_reg == '0) || match_hf_reg) && (pos_reg < HF_LEN)
                        && (s_rx_byte[6:0] == rrlp_pkg::IDENT_HF[pos_reg[3:0]]);
    assign match_lf_cur  = is_term ? match_lf_reg : match_lf_next;
    assign match_hf_cur  = is_term ? match_hf_reg : match_hf_next;

    assign is_dash   = (first_reg == rrlp_pkg::CH_DASH);
    assign empty_tag = line_end && is_dash && (len == PW'(1));
    assign hit_lf    = line_end && (len == LF_LEN) && match_lf_cur;
    assign hit_hf    = line_end && (len == HF_LEN) && match_hf_cur;

    always_comb begin
        model_next = model_reg;
        if (hit_lf) begin
            model_next = rrlp_pkg::MODEL_LF;
        end else if (hit_hf) begin
            model_next = rrlp_pkg::MODEL_HF;
        end
    end

    assign status.single   = empty_tag || hit_lf || hit_hf;
    assign status.tags     = line_end && is_dash && (len > PW'(1));
    assign status.out_last = m_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            model_reg <= rrlp_pkg::MODEL_NONE;
        end else if (cmd.take) begin
            if (s_action) begin
                pos_reg   <= '0;
                model_reg <= rrlp_pkg::MODEL_NONE;
            end else if (line_end) begin
                pos_reg   <= '0;
                model_reg <= model_next;
            end else if (is_store) begin
                pos_reg <= pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && is_store) begin
            line_mem[pos_reg] <= s_rx_byte[6:0];
            match_lf_reg      <= match_lf_next;
            match_hf_reg      <= match_hf_next;
            if (pos_reg == '0) begin
                first_reg <= s_rx_byte[6:0];
            end
        end
        if (cmd.rd) begin
            rd_data_reg <= line_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            idx_reg        <= PW'(1);
            tag_last_reg   <= len - PW'(1);
            m_kind         <= empty_tag ? rrlp_pkg::KIND_EMPTY : rrlp_pkg::KIND_IDENT;
            m_tag_char     <= '0;
            m_last         <= 1'b1;
            m_reader_model <= model_next;
        end else if (cmd.load_tag) begin
            idx_reg        <= idx_reg + PW'(1);
            m_kind         <= rrlp_pkg::KIND_TAG;
            m_tag_char     <= rd_data_reg;
            m_last         <= (idx_reg == tag_last_reg);
            m_reader_model <= model_reg;
        end
    end

endmodule

`default_nettype wire

### sv/reader_response_line_parser_unit.sv
// Top level of the reader response line parser.
`default_nettype none

// Takes one received byte (or a restart) per input beat and assembles reader response
// lines in a LINE_LEN-entry line store. A line ends on CR, LF, NUL or after LINE_LEN-1
// stored bytes; a tag line then yields one result beat per character after the dash, and
// a line equal to a reader identity string yields one identified beat. An input beat that
// ends no line with results leaves the parser ready for the next beat. A single-result
// line is loaded into the result register and waits for m_ready. For a tag line, each
// character passes through a registered read of the line store, then the result register,
// and waits for m_ready. No input beat is taken while results of a line are still pending.
module reader_response_line_parser_unit #(
    parameter int LINE_LEN = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [6:0]      m_tag_char,
    output logic            m_last,
    output logic [1:0]      m_reader_model
);

    rrlp_pkg::cmd_t    cmd;
    rrlp_pkg::status_t status;

    rrlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrlp_datapath #(
        .LINE_LEN (LINE_LEN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_action       (s_action),
        .s_rx_byte      (s_rx_byte),
        .m_kind         (m_kind),
        .m_tag_char     (m_tag_char),
        .m_last         (m_last),
        .m_reader_model (m_reader_model)
    );

    // Input is never taken while a result beat is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input ready while a result beat is pending");

    // Empty-tag and identified results are always the only and last beat of their line.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != rrlp_pkg::KIND_TAG)) |-> m_last)
        else $error("single result beat without last");

    // An identified beat always reports a found reader.
    a_ident_model: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == rrlp_pkg::KIND_IDENT)) |->
            (m_reader_model == rrlp_pkg::MODEL_LF || m_reader_model == rrlp_pkg::MODEL_HF))
        else $error("identified beat without a reader model");

    // A non-final tag beat is followed by further work, never by a return to input.
    a_tag_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("tag line ended before its last character");

endmodule

`default_nettype wire
